// ===== hw/rtl/sbsph_pkg.sv =====
// shared types, constants and log2 helpers of the spectrum smoothing and peak hold core
package sbsph_pkg;

    localparam int BIN_W       = 10;
    localparam int MAG_W       = 32;
    localparam int LVL_W       = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int NUM_BINS_DEF = 1024;
    localparam int FFT_SIZE     = 2048;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DB    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DB    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_DEC  = 2'd3;

    // register reset values
    localparam logic signed [15:0] MIN_DB_RESET   = -16'sd25600;
    localparam logic signed [15:0] MAX_DB_RESET   = 16'sd0;
    localparam logic [8:0]         SMOOTH_RESET   = 9'd128;
    localparam logic [11:0]        PEAK_DEC_RESET = 12'd154;

    localparam logic [8:0] COEFF_MAX = 9'd256;

    // log2(1e-6) in q16 and 20*log10(2) in q16
    localparam int LOG2_FLOOR  = -1306235;
    localparam int DB_PER_LOG2 = 394566;

    typedef struct packed {
        logic signed [15:0] min_db;
        logic signed [15:0] max_db;
        logic [8:0]         coeff;
        logic [11:0]        decay;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] smoothed;
        logic signed [15:0] peak;
    } st_t;

    // one bin with its levels: write-back bus and result item
    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        st_t              st;
    } lvl_t;

    // front pipeline to state update stage
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [BIN_W-1:0]   bin;
        logic signed [15:0] db;
        st_t                st;
    } upd_t;

    localparam st_t ST_RESET = '{smoothed: MIN_DB_RESET, peak: MIN_DB_RESET};

    // log2(1 + k/16) in q16, k = 0..16
    function automatic logic [16:0] log2_frac(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56228;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // log2 in q16 of a constant, used at elaboration only
    function automatic int log2_q16(input logic [31:0] x);
        int          p;
        logic [31:0] nrm;
        logic [4:0]  idx;
        logic [11:0] rem;
        logic [16:0] lo;
        logic [16:0] hi;
        p = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                p = i;
            end
        end
        nrm = x << (31 - p);
        idx = {1'b0, nrm[30:27]};
        rem = nrm[26:15];
        lo  = log2_frac(idx);
        hi  = log2_frac(idx + 5'd1);
        return p * 65536 + int'(lo) + ((int'(hi) - int'(lo)) * int'(rem)) / 4096;
    endfunction

    // q16 offset: 16 fraction bits of the magnitude, times 2, over fft size
    localparam int LOG2_OFFSET = 15 * 65536 + log2_q16(32'(FFT_SIZE));

    // newest in-flight value of a bin wins over an older copy
    function automatic st_t fwd_st(input lvl_t wb, input logic [BIN_W-1:0] bin,
                                   input st_t cur);
        return (wb.valid && (wb.bin == bin)) ? wb.st : cur;
    endfunction

endpackage

// ===== hw/rtl/sbsph_ram.sv =====
// generic simple dual port ram with registered read
module sbsph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sbsph_front.sv =====
// front pipeline: leading one, log2 interpolation, db scaling, clamp, state forwarding
module sbsph_front #(
    parameter int NUM_BINS = sbsph_pkg::NUM_BINS_DEF
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [sbsph_pkg::BIN_W-1:0]  in_bin,
    input  logic [sbsph_pkg::MAG_W-1:0]  in_mag,
    input  sbsph_pkg::st_t               rdata,
    input  sbsph_pkg::lvl_t              wb,
    input  sbsph_pkg::cfg_t              cfg,
    output sbsph_pkg::upd_t              out
);

    localparam logic signed [23:0] L_OFFSET = 24'(sbsph_pkg::LOG2_OFFSET);
    localparam logic signed [23:0] L_FLOOR  = 24'(sbsph_pkg::LOG2_FLOOR);
    localparam logic signed [19:0] DB_K     = 20'(sbsph_pkg::DB_PER_LOG2);
    localparam logic signed [43:0] RND      = 44'sh800000;

    // stage a
    logic                        a_valid_reg;
    logic                        a_inr_reg;
    logic [sbsph_pkg::BIN_W-1:0] a_bin_reg;
    logic [sbsph_pkg::MAG_W-1:0] a_mag_reg;
    logic                        a_fwd_reg;
    sbsph_pkg::st_t              a_fwd_st_reg;
    // stage b
    logic                        b_valid_reg;
    logic                        b_inr_reg;
    logic [sbsph_pkg::BIN_W-1:0] b_bin_reg;
    logic [4:0]                  b_p_reg;
    logic [15:0]                 b_frac_reg;
    logic                        b_zero_reg;
    sbsph_pkg::st_t              b_st_reg;
    // stage c
    logic                        c_valid_reg;
    logic                        c_inr_reg;
    logic [sbsph_pkg::BIN_W-1:0] c_bin_reg;
    logic signed [23:0]          c_l_reg;
    sbsph_pkg::st_t              c_st_reg;
    // stage d
    logic                        d_valid_reg;
    logic                        d_inr_reg;
    logic [sbsph_pkg::BIN_W-1:0] d_bin_reg;
    logic signed [43:0]          d_prod_reg;
    sbsph_pkg::st_t              d_st_reg;

    logic                        in_inr;
    logic [4:0]                  b_p_next;
    logic [15:0]                 b_frac_next;
    logic [31:0]                 a_norm;
    sbsph_pkg::st_t              a_st;
    logic [3:0]                  b_idx;
    logic [11:0]                 b_rem;
    logic [16:0]                 b_lo;
    logic [16:0]                 b_hi;
    logic [12:0]                 b_step;
    logic [24:0]                 b_mul;
    logic [21:0]                 b_log2;
    logic signed [23:0]          b_l;
    logic signed [23:0]          c_l_next;
    logic signed [43:0]          d_prod_next;
    logic signed [43:0]          d_rnd;
    logic signed [19:0]          d_db;
    logic signed [19:0]          d_min;
    logic signed [19:0]          d_max;
    logic signed [19:0]          d_lo_cl;
    logic signed [19:0]          d_cl;

    assign in_inr = 32'(in_bin) < NUM_BINS;

    // stage a: leading one and left-aligned fraction
    always_comb begin
        b_p_next = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (a_mag_reg[i]) begin
                b_p_next = 5'(i);
            end
        end
        a_norm      = a_mag_reg << (5'd31 - b_p_next);
        b_frac_next = a_norm[30:15];
        a_st        = a_fwd_reg ? a_fwd_st_reg : rdata;
    end

    // stage b: table plus linear interpolation, offset and floor
    always_comb begin
        b_idx    = b_frac_reg[15:12];
        b_rem    = b_frac_reg[11:0];
        b_lo     = sbsph_pkg::log2_frac({1'b0, b_idx});
        b_hi     = sbsph_pkg::log2_frac({1'b0, b_idx} + 5'd1);
        b_step   = 13'(b_hi - b_lo);
        b_mul    = 25'(b_step) * 25'(b_rem);
        b_log2   = {1'b0, b_p_reg, 16'd0} + 22'(b_lo) + 22'(b_mul[24:12]);
        b_l      = $signed({2'b00, b_log2}) - L_OFFSET;
        c_l_next = (b_zero_reg || (b_l < L_FLOOR)) ? L_FLOOR : b_l;
    end

    // stage c: scale to db
    assign d_prod_next = c_l_reg * DB_K;

    // stage d: round half up and clamp
    always_comb begin
        d_rnd   = d_prod_reg + RND;
        d_db    = $signed(d_rnd[43:24]);
        d_min   = 20'(cfg.min_db);
        d_max   = 20'(cfg.max_db);
        d_lo_cl = (d_db < d_min) ? d_min : d_db;
        d_cl    = (d_lo_cl > d_max) ? d_max : d_lo_cl;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_inr_reg    <= in_inr;
            a_bin_reg    <= in_bin;
            a_mag_reg    <= in_mag;
            a_fwd_reg    <= wb.valid && (wb.bin == in_bin);
            a_fwd_st_reg <= wb.st;

            b_inr_reg    <= a_inr_reg;
            b_bin_reg    <= a_bin_reg;
            b_p_reg      <= b_p_next;
            b_frac_reg   <= b_frac_next;
            b_zero_reg   <= (a_mag_reg == '0);
            b_st_reg     <= sbsph_pkg::fwd_st(wb, a_bin_reg, a_st);

            c_inr_reg    <= b_inr_reg;
            c_bin_reg    <= b_bin_reg;
            c_l_reg      <= c_l_next;
            c_st_reg     <= sbsph_pkg::fwd_st(wb, b_bin_reg, b_st_reg);

            d_inr_reg    <= c_inr_reg;
            d_bin_reg    <= c_bin_reg;
            d_prod_reg   <= d_prod_next;
            d_st_reg     <= sbsph_pkg::fwd_st(wb, c_bin_reg, c_st_reg);
        end
    end

    assign out.valid    = d_valid_reg;
    assign out.in_range = d_inr_reg;
    assign out.bin      = d_bin_reg;
    assign out.db       = d_cl[15:0];
    assign out.st       = d_st_reg;

endmodule

// ===== hw/rtl/sbsph_update.sv =====
// state update stage: smoothing, peak hold with decay, write-back bus
module sbsph_update (
    input  logic             clk,
    input  logic             rstn,
    input  logic             en,
    input  sbsph_pkg::cfg_t  cfg,
    input  sbsph_pkg::upd_t  d,
    output sbsph_pkg::lvl_t  wb,
    output sbsph_pkg::lvl_t  res
);

    logic                        e_valid_reg;
    logic                        e_inr_reg;
    logic [sbsph_pkg::BIN_W-1:0] e_bin_reg;
    logic signed [15:0]          e_db_reg;
    sbsph_pkg::st_t              e_st_reg;

    logic [8:0]         coeff;
    logic signed [16:0] diff;
    logic signed [26:0] prod;
    logic signed [26:0] prod_rnd;
    logic signed [18:0] step;
    logic signed [18:0] s_wide;
    logic signed [15:0] s_new;
    logic signed [16:0] pk_dec;
    logic signed [16:0] min_w;
    logic signed [15:0] pk_fl;
    sbsph_pkg::st_t     st_new;

    always_comb begin
        coeff    = (cfg.coeff > sbsph_pkg::COEFF_MAX) ? sbsph_pkg::COEFF_MAX : cfg.coeff;
        diff     = 17'(e_db_reg) - 17'(e_st_reg.smoothed);
        prod     = $signed({1'b0, coeff}) * diff;
        prod_rnd = prod + 27'sd128;
        step     = $signed(prod_rnd[26:8]);
        s_wide   = 19'(e_st_reg.smoothed) + step;
        s_new    = s_wide[15:0];
        pk_dec   = 17'(e_st_reg.peak) - $signed({5'd0, cfg.decay});
        min_w    = 17'(cfg.min_db);
        pk_fl    = (pk_dec < min_w) ? cfg.min_db : pk_dec[15:0];
        st_new.smoothed = s_new;
        st_new.peak     = (s_new > e_st_reg.peak) ? s_new : pk_fl;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            e_inr_reg <= d.in_range;
            e_bin_reg <= d.bin;
            e_db_reg  <= d.db;
            e_st_reg  <= sbsph_pkg::fwd_st(wb, d.bin, d.st);
        end
    end

    assign wb.valid  = e_valid_reg && e_inr_reg;
    assign wb.bin    = e_bin_reg;
    assign wb.st     = st_new;

    assign res.valid = e_valid_reg;
    assign res.bin   = e_bin_reg;
    assign res.st    = e_inr_reg ? st_new : '0;

endmodule

// ===== hw/rtl/sbsph_outbuf.sv =====
// two-entry output skid buffer that sets the pipeline advance
module sbsph_outbuf (
    input  logic             clk,
    input  logic             rstn,
    input  sbsph_pkg::lvl_t  in_item,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sbsph_pkg::lvl_t  out_item
);

    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    sbsph_pkg::lvl_t e0_reg;
    sbsph_pkg::lvl_t e1_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2) || out_ready;
    assign push      = in_item.valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = e0_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        case (count_reg)
            2'd0: begin
                if (push) begin
                    e0_reg <= in_item;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    e0_reg <= in_item;
                end else if (push) begin
                    e1_reg <= in_item;
                end
            end
            2'd2: begin
                if (pop) begin
                    e0_reg <= e1_reg;
                    if (push) begin
                        e1_reg <= in_item;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/spectrum_bin_smooth_peak_hold_core.sv =====
// top level of the spectrum bin smoothing and peak hold core
//
//  channel   dir  width  contents (lowest bit up)
//  s_        in   48     bin_index[9:0], magnitude[41:10], zero fill
//  m_        out  48     out_bin_index[9:0], smoothed_level[25:10], peak_level[41:26]
//  cfg_      in   16     min_db, max_db, smoothing_coeff, peak_decay at index 0..3
//
// one request per cycle outside the clearing pass and while the output buffer has room;
// a result is offered from the output buffer after the ram read at the taking edge, then
// log2, interpolation, db multiply, clamp and state update
// after reset a clearing pass over every bin address sets both levels to the reset
// min_db; s_tready stays low meanwhile, configuration writes are taken as ever
// the whole pipeline advances only when the two-entry output buffer has room,
// so a stalled m_ side holds every stage and loses nothing
// a bin that returns while still in flight gets its state forwarded from the
// update stage, so back to back requests to one bin are exact
module spectrum_bin_smooth_peak_hold_core #(
    parameter int NUM_BINS = sbsph_pkg::NUM_BINS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sbsph_pkg::S_TDATA_W-1:0]   s_tdata,   // bin_index, magnitude
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbsph_pkg::M_TDATA_W-1:0]   m_tdata,   // out_bin_index, smoothed_level, peak_level
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [sbsph_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sbsph_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_BINS - 1);

    sbsph_pkg::cfg_t  cfg_reg;
    logic             clear_busy_reg;
    logic [ADDR_W-1:0] clear_idx_reg;

    logic             en;
    logic             in_valid;
    logic [sbsph_pkg::BIN_W-1:0] in_bin;
    logic [sbsph_pkg::MAG_W-1:0] in_mag;
    sbsph_pkg::st_t   rdata;
    sbsph_pkg::lvl_t  wb;
    sbsph_pkg::lvl_t  res;
    sbsph_pkg::lvl_t  out_item;
    sbsph_pkg::upd_t  upd;

    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    sbsph_pkg::st_t   ram_wdata;

    // request fields
    assign in_bin   = s_tdata[9:0];
    assign in_mag   = s_tdata[41:10];
    assign s_tready = en && !clear_busy_reg;
    assign in_valid = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_db <= sbsph_pkg::MIN_DB_RESET;
            cfg_reg.max_db <= sbsph_pkg::MAX_DB_RESET;
            cfg_reg.coeff  <= sbsph_pkg::SMOOTH_RESET;
            cfg_reg.decay  <= sbsph_pkg::PEAK_DEC_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sbsph_pkg::REG_MIN_DB:   cfg_reg.min_db <= $signed(cfg_wdata);
                sbsph_pkg::REG_MAX_DB:   cfg_reg.max_db <= $signed(cfg_wdata);
                sbsph_pkg::REG_SMOOTH:   cfg_reg.coeff  <= cfg_wdata[8:0];
                sbsph_pkg::REG_PEAK_DEC: cfg_reg.decay  <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // clearing pass over the state ram after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
        end else if (clear_busy_reg) begin
            if (clear_idx_reg == CLR_LAST) begin
                clear_busy_reg <= 1'b0;
            end else begin
                clear_idx_reg <= clear_idx_reg + ADDR_W'(1);
            end
        end
    end

    // one ram holds both levels of a bin; write port shared by clear and update
    assign ram_we    = clear_busy_reg || (en && wb.valid);
    assign ram_waddr = clear_busy_reg ? clear_idx_reg : ADDR_W'(wb.bin);
    assign ram_wdata = clear_busy_reg ? sbsph_pkg::ST_RESET : wb.st;

    sbsph_ram #(
        .WIDTH ($bits(sbsph_pkg::st_t)),
        .DEPTH (NUM_BINS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (en),
        .raddr (ADDR_W'(in_bin)),
        .rdata (rdata)
    );

    // log2 to db front pipeline, four stages
    sbsph_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk      (aclk),
        .rstn     (aresetn),
        .en       (en),
        .in_valid (in_valid),
        .in_bin   (in_bin),
        .in_mag   (in_mag),
        .rdata    (rdata),
        .wb       (wb),
        .cfg      (cfg_reg),
        .out      (upd)
    );

    // smoothing and peak hold
    sbsph_update u_update (
        .clk  (aclk),
        .rstn (aresetn),
        .en   (en),
        .cfg  (cfg_reg),
        .d    (upd),
        .wb   (wb),
        .res  (res)
    );

    // output skid buffer, its room drives the pipeline advance
    sbsph_outbuf u_outbuf (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_item   (res),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {6'd0, out_item.st.peak, out_item.st.smoothed, out_item.bin};

    // no request enters while the state ram is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // the clearing pass owns the write port alone
    a_no_update_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !(en && wb.valid))
        else $error("state update collides with clearing pass");

    // clearing ends right after the last address
    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (clear_busy_reg && (clear_idx_reg == CLR_LAST)) |=> !clear_busy_reg)
        else $error("clearing pass did not end at last address");

    // a stall freezes the update stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(wb.valid) && $stable(wb.bin)))
        else $error("update stage moved during stall");

endmodule
